[hdl/stereo_frame_pairing_assert.svh]
// assertion macros for the stereo frame pairing block
// depends on nothing; included by the top level
`ifndef STEREO_FRAME_PAIRING_ASSERT_SVH
`define STEREO_FRAME_PAIRING_ASSERT_SVH
`ifndef SYNTHESIS
`define SFP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SFP_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SFP_ASSERT(label, clk, rst, prop)
`define SFP_ASSERT_RST(label, clk, prop)
`endif
`endif

[hdl/sfp_pkg.sv]
// shared constants for the stereo frame pairing block
// no dependencies
package sfp_pkg;
   localparam int TIME_W = 40;
   localparam int ID_W = 32;
   localparam int WIN_W = 10;
   localparam int MAX_RESULTS = 16;
   localparam logic [1:0] MODE_LEFT = 2'd0;
   localparam logic [1:0] MODE_RIGHT = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int WIN_RESET = 20;
   localparam logic [0:0] ADDR_WINDOW = 1'b0;
endpackage

[hdl/stereo_frame_pairing.sv]
// stereo frame pairing: left/right frame tables and tick-driven pairing pass
// depends on sfp_pkg and stereo_frame_pairing_assert.svh
//
// usage:
//  - req_ channel: pulse start with req_mode, req_time_ms, req_frame_id while
//    busy is low. mode 0 inserts a left frame, 1 a right frame, 2 runs a tick.
//  - rsp_ channel: each released left frame shows for one cycle with
//    rsp_strobe high; rsp_last marks the final release of a tick.
//  - APB-style port: one register (pair window), written when paddr[2] is 0.
// timing:
//  - one shared compare unit walks the table one entry per cycle.
//  - an arrival whose timestamp is already held overwrites that entry after
//    the match scan; else an oldest/free scan picks the slot.
//  - a tick runs per release an oldest left scan, a nearest right scan and
//    an emit, then a closing left scan (plus a right scan and an emit when a
//    waiting left frame stops the drain), then the right purge.
//  - a release shows in the cycle after the next one is decided, the last
//    once the purge has begun; busy stays high and the receiver cannot stall.
// reset (synchronous): valid bits, counter and state clear; window returns to 20.
`include "stereo_frame_pairing_assert.svh"
module stereo_frame_pairing #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_mode,
   input  logic [sfp_pkg::TIME_W-1:0] req_time_ms,
   input  logic [sfp_pkg::ID_W-1:0]  req_frame_id,
   output logic                      rsp_strobe,
   output logic [sfp_pkg::TIME_W-1:0] rsp_left_time_ms,
   output logic [sfp_pkg::ID_W-1:0]  rsp_left_id,
   output logic [sfp_pkg::TIME_W-1:0] rsp_right_time_ms,
   output logic [sfp_pkg::ID_W-1:0]  rsp_right_id,
   output logic                      rsp_paired,
   output logic [31:0]               rsp_released_count,
   output logic                      rsp_last,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int TW = sfp_pkg::TIME_W;
   localparam int DW = sfp_pkg::ID_W;
   localparam int NW = $clog2(sfp_pkg::MAX_RESULTS + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1; // arrival: look for equal timestamp
   localparam logic [2:0] S_SLOT  = 3'd2; // arrival: free slot or oldest
   localparam logic [2:0] S_LOLD  = 3'd3; // tick: oldest left entry
   localparam logic [2:0] S_RNEAR = 3'd4; // tick: nearest right entry
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_PURGE = 3'd6;

   logic [TW-1:0] lt_mem [TABLE_DEPTH];
   logic [DW-1:0] lid_mem [TABLE_DEPTH];
   logic [TW-1:0] rt_mem [TABLE_DEPTH];
   logic [DW-1:0] rid_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] lv_ff, lv_in, rv_ff, rv_in;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        side_ff, side_in; // 0 left table, 1 right table
   logic [TW-1:0] t_ff, t_in;
   logic [DW-1:0] id_ff, id_in;
   logic [sfp_pkg::WIN_W-1:0] win_ff, win_in;
   logic [31:0] rel_ff, rel_in;
   logic [NW-1:0] n_ff, n_in;
   // best candidate of the running scan
   logic        bv_ff, bv_in;
   logic [IW-1:0] bi_ff, bi_in;
   logic [TW-1:0] bt_ff, bt_in;
   logic [TW:0] bd_ff, bd_in;
   logic        free_ff, free_in;
   logic [IW-1:0] fi_ff, fi_in;
   // held left selection
   logic [IW-1:0] li_ff, li_in;
   logic [TW-1:0] lt_ff, lt_in;
   // write port
   logic        we;
   logic        we_side;
   logic [IW-1:0] wa;
   logic [TW-1:0] wt;
   logic [DW-1:0] wid;
   logic [TW-1:0] o_lt_ff, o_lt_in, o_rt_ff, o_rt_in;
   logic [DW-1:0] o_lid_ff, o_lid_in, o_rid_ff, o_rid_in;
   logic        o_p_ff, o_p_in;

   // shared unit: one entry's time against the reference, absolute distance
   logic [IW-1:0] idx;
   logic          ev;
   logic [TW-1:0] et;
   logic [TW:0]   delta;
   logic          cur_valid;

   assign idx = cnt_ff[IW-1:0];
   assign cur_valid = side_ff ? rv_ff[idx] : lv_ff[idx];
   assign et = side_ff ? rt_mem[idx] : lt_mem[idx];
   assign ev = (cnt_ff < CW'(TABLE_DEPTH)) && cur_valid;
   always_comb begin
      logic [TW-1:0] ref_t;
      ref_t = (state_ff == S_RNEAR) ? lt_ff : t_ff;
      if (et >= ref_t) delta = {1'b0, et - ref_t};
      else delta = {1'b0, ref_t - et};
   end

   function automatic logic older(input logic [TW-1:0] now, input logic [TW-1:0] t,
                                  input logic [TW:0] lim);
      logic [TW-1:0] d;
      d = now - t;
      older = (now > t) && ({1'b0, d} > lim);
   endfunction

   assign pready = 1'b1;
   assign busy = (state_ff != S_IDLE);
   assign prdata = {{(32-sfp_pkg::WIN_W){1'b0}}, win_ff};

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; side_in = side_ff;
      t_in = t_ff; id_in = id_ff; win_in = win_ff; rel_in = rel_ff;
      n_in = n_ff; bv_in = bv_ff; bi_in = bi_ff; bt_in = bt_ff; bd_in = bd_ff;
      free_in = free_ff; fi_in = fi_ff; li_in = li_ff;
      lt_in = lt_ff; lv_in = lv_ff; rv_in = rv_ff;
      we = 1'b0; we_side = side_ff; wa = idx; wt = t_ff; wid = id_ff;
      o_lt_in = o_lt_ff; o_rt_in = o_rt_ff;
      o_lid_in = o_lid_ff; o_rid_in = o_rid_ff; o_p_in = o_p_ff;
      if (psel && penable && pwrite && paddr[2] == sfp_pkg::ADDR_WINDOW)
         win_in = pwdata[sfp_pkg::WIN_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               t_in = req_time_ms; id_in = req_frame_id; cnt_in = '0;
               bv_in = 1'b0; free_in = 1'b0; n_in = '0;
               case (req_mode)
                  sfp_pkg::MODE_LEFT: begin side_in = 1'b0; state_in = S_FIND; end
                  sfp_pkg::MODE_RIGHT: begin side_in = 1'b1; state_in = S_FIND; end
                  sfp_pkg::MODE_TICK: begin side_in = 1'b0; state_in = S_LOLD; end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FIND: begin
            if (cnt_ff == CW'(TABLE_DEPTH)) begin
               if (bv_ff) begin
                  we = 1'b1; wa = bi_ff; wt = t_ff; state_in = S_IDLE;
               end else begin
                  cnt_in = '0; state_in = S_SLOT;
               end
            end else begin
               if (ev && et == t_ff && !bv_ff) begin bv_in = 1'b1; bi_in = idx; end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SLOT: begin
            if (cnt_ff == CW'(TABLE_DEPTH)) begin
               we = 1'b1; wa = free_ff ? fi_ff : bi_ff;
               if (side_ff) rv_in[wa] = 1'b1; else lv_in[wa] = 1'b1;
               state_in = S_IDLE;
            end else begin
               if (!ev && !free_ff) begin free_in = 1'b1; fi_in = idx; end
               if (ev && (!bv_ff || et < bt_ff)) begin
                  bv_in = 1'b1; bi_in = idx; bt_in = et;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_LOLD: begin
            if (cnt_ff == CW'(TABLE_DEPTH)) begin
               if (!bv_ff || n_ff == NW'(sfp_pkg::MAX_RESULTS)) begin
                  side_in = 1'b1; cnt_in = '0; state_in = S_PURGE;
               end else begin
                  li_in = bi_ff; lt_in = bt_ff; side_in = 1'b1; cnt_in = '0;
                  bv_in = 1'b0; state_in = S_RNEAR;
               end
            end else begin
               if (ev && (!bv_ff || et < bt_ff)) begin
                  bv_in = 1'b1; bi_in = idx; bt_in = et;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RNEAR: begin
            if (cnt_ff == CW'(TABLE_DEPTH)) begin
               state_in = S_EMIT;
            end else begin
               if (ev && delta <= {1'b0, {(TW-sfp_pkg::WIN_W){1'b0}}, win_ff} &&
                   (!bv_ff || delta < bd_ff || (delta == bd_ff && et < bt_ff))) begin
                  bv_in = 1'b1; bi_in = idx; bt_in = et; bd_in = delta;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!bv_ff && !older(t_ff, lt_ff,
                                 {{(TW+1-sfp_pkg::WIN_W){1'b0}}, win_ff})) begin
               side_in = 1'b1; cnt_in = '0; state_in = S_PURGE;
            end else begin
               o_lt_in = lt_ff; o_lid_in = lid_mem[li_ff];
               o_rt_in = bv_ff ? bt_ff : '0; o_rid_in = bv_ff ? rid_mem[bi_ff] : '0;
               o_p_in = bv_ff;
               if (bv_ff) rv_in[bi_ff] = 1'b0;
               lv_in[li_ff] = 1'b0;
               rel_in = rel_ff + 32'd1;
               n_in = n_ff + 1'b1;
               side_in = 1'b0; cnt_in = '0; bv_in = 1'b0; state_in = S_LOLD;
            end
         end
         S_PURGE: begin
            if (cnt_ff == CW'(TABLE_DEPTH)) begin
               state_in = S_IDLE;
            end else begin
               if (ev && older(t_ff, et, {{(TW-1-sfp_pkg::WIN_W){1'b0}}, win_ff, 2'b00}))
                  rv_in[idx] = 1'b0;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a release is held until the next one is decided or the tick ends, so that last is known when it is shown
   logic pend_ff;
   logic [TW-1:0] p_lt_ff, p_rt_ff;
   logic [DW-1:0] p_lid_ff, p_rid_ff;
   logic p_p_ff;
   logic [31:0] p_cnt_ff;
   logic tick_end;
   assign tick_end = (state_ff == S_PURGE) && (cnt_ff == '0);
   logic new_rel;
   assign new_rel = (state_ff == S_EMIT) && (state_in == S_LOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; lv_ff <= '0; rv_ff <= '0;
         win_ff <= sfp_pkg::WIN_W'(sfp_pkg::WIN_RESET); rel_ff <= '0;
         n_ff <= '0; bv_ff <= 1'b0; free_ff <= 1'b0; pend_ff <= 1'b0;
         rsp_strobe <= 1'b0; side_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; lv_ff <= lv_in; rv_ff <= rv_in;
         win_ff <= win_in; rel_ff <= rel_in; n_ff <= n_in; bv_ff <= bv_in;
         free_ff <= free_in; side_ff <= side_in;
         rsp_strobe <= 1'b0;
         if (pend_ff && (new_rel || tick_end)) begin
            rsp_strobe <= 1'b1;
            rsp_last <= tick_end;
            rsp_left_time_ms <= p_lt_ff; rsp_left_id <= p_lid_ff;
            rsp_right_time_ms <= p_rt_ff; rsp_right_id <= p_rid_ff;
            rsp_paired <= p_p_ff; rsp_released_count <= p_cnt_ff;
         end
         if (new_rel) pend_ff <= 1'b1;
         else if (tick_end) pend_ff <= 1'b0;
      end
      t_ff <= t_in; id_ff <= id_in; bi_ff <= bi_in; bt_ff <= bt_in; bd_ff <= bd_in;
      fi_ff <= fi_in; li_ff <= li_in; lt_ff <= lt_in;
      o_lt_ff <= o_lt_in; o_rt_ff <= o_rt_in; o_lid_ff <= o_lid_in;
      o_rid_ff <= o_rid_in; o_p_ff <= o_p_in;
      if (new_rel) begin
         p_lt_ff <= o_lt_in; p_lid_ff <= o_lid_in; p_rt_ff <= o_rt_in;
         p_rid_ff <= o_rid_in; p_p_ff <= o_p_in; p_cnt_ff <= rel_in;
      end
      if (we) begin
         if (we_side) begin rt_mem[wa] <= wt; rid_mem[wa] <= wid; end
         else begin lt_mem[wa] <= wt; lid_mem[wa] <= wid; end
      end
   end

   `SFP_ASSERT(a_idle_no_busy, clock, reset, (state_ff == S_IDLE) |-> !busy)
   `SFP_ASSERT(a_strobe_only_busy, clock, reset, rsp_strobe |-> $past(busy))
   `SFP_ASSERT(a_count_step, clock, reset,
      new_rel |=> (rel_ff == $past(rel_ff) + 32'd1))
   `SFP_ASSERT(a_emit_limit, clock, reset, n_ff <= NW'(sfp_pkg::MAX_RESULTS))
endmodule
